### hdl/bmm_pkg.sv
// Shared constants, codes and the command type of the banked memory mapper.
`timescale 1ns / 1ps

package bmm_pkg;

    // Sizes of the address map and the stores
    localparam int ROM_BANKS_DEF = 32;
    localparam int BANK_BYTES    = 16384;
    localparam int BANK_AW       = 14;
    localparam int SYS_RAM_BYTES = 8192;
    localparam int SYS_AW        = 13;
    localparam int CART_BYTES    = 32768;
    localparam int CART_AW       = 15;
    localparam int PAGE_W        = 6;
    localparam int QUEUE_DEPTH   = 2;

    // Operation codes on the input channel
    localparam logic [2:0] OP_READ_BYTE  = 3'd0;
    localparam logic [2:0] OP_WRITE_BYTE = 3'd1;
    localparam logic [2:0] OP_READ_WORD  = 3'd2;
    localparam logic [2:0] OP_WRITE_WORD = 3'd3;
    localparam logic [2:0] OP_LOAD_ROM   = 3'd4;

    // Command classes after decode
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_LOAD  = 2'd3;

    // Source of a read byte
    localparam logic [1:0] SRC_ZERO = 2'd0;
    localparam logic [1:0] SRC_ROM  = 2'd1;
    localparam logic [1:0] SRC_CART = 2'd2;
    localparam logic [1:0] SRC_SYS  = 2'd3;

    // Control register addresses and map constants
    localparam logic [15:0] ADDR_RAM_SEL = 16'hfffc;
    localparam logic [15:0] ADDR_PAGE0   = 16'hfffd;
    localparam logic [15:0] ADDR_PAGE1   = 16'hfffe;
    localparam logic [15:0] ADDR_PAGE2   = 16'hffff;
    localparam logic [13:0] FIXED_LIMIT  = 14'h0400;
    localparam logic [5:0]  MASK_RESET   = 6'd31;

    // Slot numbers
    localparam logic [1:0] SLOT0 = 2'd0;
    localparam logic [1:0] SLOT1 = 2'd1;
    localparam logic [1:0] SLOT2 = 2'd2;
    localparam logic [1:0] SLOT3 = 2'd3;

    // Decoded command passed from the front to the back
    typedef struct packed {
        logic [1:0]  kind;
        logic        word;
        logic [15:0] addr;
        logic [15:0] wdata;
        logic [18:0] rom_offset;
        logic [7:0]  rom_byte;
        logic        load_ok;
    } t_cmd;

endpackage

### hdl/bmm_front.sv
// Front end: accept input words, classify them and hold them in a register stage.
`timescale 1ns / 1ps

module bmm_front #(
    parameter int ROM_BANKS = bmm_pkg::ROM_BANKS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [2:0]          i_operation,
    input  logic [15:0]         i_address,
    input  logic [15:0]         i_write_data,
    input  logic [18:0]         i_rom_offset,
    input  logic [7:0]          i_rom_byte,
    output logic                o_valid,
    output bmm_pkg::t_cmd       o_cmd,
    input  logic                i_ready
);

    localparam logic [20:0] ROM_BYTES = 21'(ROM_BANKS * bmm_pkg::BANK_BYTES);

    logic          r_valid;
    bmm_pkg::t_cmd r_cmd;
    bmm_pkg::t_cmd n_cmd;

    // Decode the operation into a class and a width
    always_comb begin
        n_cmd.addr       = i_address;
        n_cmd.wdata      = i_write_data;
        n_cmd.rom_offset = i_rom_offset;
        n_cmd.rom_byte   = i_rom_byte;
        n_cmd.load_ok    = ({2'b00, i_rom_offset} < ROM_BYTES);
        unique case (i_operation)
            bmm_pkg::OP_READ_BYTE: begin
                n_cmd.kind = bmm_pkg::KIND_READ;
                n_cmd.word = 1'b0;
            end
            bmm_pkg::OP_WRITE_BYTE: begin
                n_cmd.kind = bmm_pkg::KIND_WRITE;
                n_cmd.word = 1'b0;
            end
            bmm_pkg::OP_READ_WORD: begin
                n_cmd.kind = bmm_pkg::KIND_READ;
                n_cmd.word = 1'b1;
            end
            bmm_pkg::OP_WRITE_WORD: begin
                n_cmd.kind = bmm_pkg::KIND_WRITE;
                n_cmd.word = 1'b1;
            end
            bmm_pkg::OP_LOAD_ROM: begin
                n_cmd.kind = bmm_pkg::KIND_LOAD;
                n_cmd.word = 1'b0;
            end
            default: begin
                n_cmd.kind = bmm_pkg::KIND_NONE;
                n_cmd.word = 1'b0;
            end
        endcase
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

    // Hold the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Capture the decoded word
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

### hdl/bmm_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module bmm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  bmm_pkg::t_cmd i_cmd,
    output logic          o_valid,
    output bmm_pkg::t_cmd o_cmd,
    input  logic          i_ready
);

    localparam int DEPTH = bmm_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [PW:0]   FULL     = (PW + 1)'(DEPTH);

    bmm_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_count;
    logic          push;
    logic          pop;

    assign o_ready = (r_count != FULL);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store incoming words
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### hdl/bmm_back.sv
// Back end: paging registers, memories, byte sequencer and result register.
`timescale 1ns / 1ps

module bmm_back #(
    parameter int ROM_BANKS = bmm_pkg::ROM_BANKS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  bmm_pkg::t_cmd i_cmd,
    input  logic          i_cfg_valid,
    input  logic [5:0]    i_cfg_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [15:0]   o_read_data
);

    localparam int ROM_DEPTH = ROM_BANKS * bmm_pkg::BANK_BYTES;
    localparam int ROM_AW    = $clog2(ROM_DEPTH);
    localparam int CART_AW   = bmm_pkg::CART_AW;
    localparam int SYS_AW    = bmm_pkg::SYS_AW;
    localparam logic [6:0] BANK_LIMIT = 7'(ROM_BANKS);
    localparam logic [CART_AW-1:0] CLR_LAST = {CART_AW{1'b1}};

    localparam logic ST_CLEAR = 1'b0;
    localparam logic ST_RUN   = 1'b1;

    // Stores
    logic [7:0] r_rom  [ROM_DEPTH];
    logic [7:0] r_cart [bmm_pkg::CART_BYTES];
    logic [7:0] r_sys  [bmm_pkg::SYS_RAM_BYTES];
    logic [7:0] r_rom_q;
    logic [7:0] r_cart_q;
    logic [7:0] r_sys_q;

    // Control state
    logic               r_state;
    logic [CART_AW-1:0] r_clr_cnt;
    logic [5:0]         r_mask;
    logic [5:0]         r_page0;
    logic [5:0]         r_page1;
    logic [5:0]         r_page2;
    logic [7:0]         r_ram_sel;
    logic               r_byte;

    // Response stage and result register
    logic        r_tag_v;
    logic        r_tag_last;
    logic        r_tag_word;
    logic [1:0]  r_tag_src;
    logic [7:0]  r_lo;
    logic        r_out_valid;
    logic [15:0] r_out_data;

    logic [15:0]        cur_addr;
    logic [7:0]         cur_wbyte;
    logic [1:0]         slot;
    logic [13:0]        off;
    logic               last;
    logic               out_free;
    logic               issue;
    logic               clearing;
    logic               is_write;
    logic               is_load;
    logic [5:0]         bank;
    logic [1:0]         src;
    logic [19:0]        rom_lin;
    logic [19:0]        rom_ld;
    logic [ROM_AW-1:0]  rom_addr;
    logic [CART_AW-1:0] cart_idx;
    logic [CART_AW-1:0] cart_addr;
    logic               cart_we;
    logic [7:0]         cart_wdata;
    logic [SYS_AW-1:0]  sys_addr;
    logic               sys_we;
    logic [7:0]         sys_wdata;
    logic [7:0]         rsp_byte;

    // Pick the byte of the current command
    assign cur_addr  = r_byte ? (i_cmd.addr + 16'd1) : i_cmd.addr;
    assign cur_wbyte = r_byte ? i_cmd.wdata[15:8] : i_cmd.wdata[7:0];
    assign slot      = cur_addr[15:14];
    assign off       = cur_addr[13:0];
    assign last      = !i_cmd.word || r_byte;

    // Issue a command's last byte only when the result register will have room
    assign clearing = (r_state == ST_CLEAR);
    assign out_free = (!r_out_valid || i_out_ready) && !(r_tag_v && r_tag_last);
    assign issue    = !clearing && i_valid && (!last || out_free);
    assign o_ready  = issue && last;
    assign is_write = issue && (i_cmd.kind == bmm_pkg::KIND_WRITE);
    assign is_load  = issue && (i_cmd.kind == bmm_pkg::KIND_LOAD) && i_cmd.load_ok;

    // Route the byte address to a store
    always_comb begin
        bank = r_page0;
        src  = bmm_pkg::SRC_ROM;
        unique case (slot)
            bmm_pkg::SLOT0: bank = (off < bmm_pkg::FIXED_LIMIT) ? 6'd0 : r_page0;
            bmm_pkg::SLOT1: bank = r_page1;
            bmm_pkg::SLOT2: begin
                bank = r_page2;
                if (r_ram_sel[3]) begin
                    src = bmm_pkg::SRC_CART;
                end
            end
            default: src = bmm_pkg::SRC_SYS;
        endcase
        if (src == bmm_pkg::SRC_ROM && {1'b0, bank} >= BANK_LIMIT) begin
            src = bmm_pkg::SRC_ZERO;
        end
    end

    assign rom_lin  = {bank, off};
    assign rom_ld   = {1'b0, i_cmd.rom_offset};
    assign rom_addr = is_load ? rom_ld[ROM_AW-1:0] : rom_lin[ROM_AW-1:0];
    assign cart_idx = {r_ram_sel[2], off};

    // Clearing pass owns the RAM ports after reset
    assign cart_addr  = clearing ? r_clr_cnt : cart_idx;
    assign cart_we    = clearing || (is_write && slot == bmm_pkg::SLOT2 && r_ram_sel[3]);
    assign cart_wdata = clearing ? 8'h00 : cur_wbyte;
    assign sys_addr   = clearing ? r_clr_cnt[SYS_AW-1:0] : cur_addr[SYS_AW-1:0];
    assign sys_we     = clearing || (is_write && slot == bmm_pkg::SLOT3);
    assign sys_wdata  = clearing ? 8'h00 : cur_wbyte;

    // ROM store
    always_ff @(posedge i_clk) begin
        if (is_load) begin
            r_rom[rom_addr] <= i_cmd.rom_byte;
        end
        r_rom_q <= r_rom[rom_addr];
    end

    // Cartridge RAM
    always_ff @(posedge i_clk) begin
        if (cart_we) begin
            r_cart[cart_addr] <= cart_wdata;
        end
        r_cart_q <= r_cart[cart_addr];
    end

    // System RAM
    always_ff @(posedge i_clk) begin
        if (sys_we) begin
            r_sys[sys_addr] <= sys_wdata;
        end
        r_sys_q <= r_sys[sys_addr];
    end

    // Sweep the RAMs after reset, then run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + 1'b1;
                    if (r_clr_cnt == CLR_LAST) begin
                        r_state <= ST_RUN;
                    end
                end
                default: r_state <= ST_RUN;
            endcase
        end
    end

    // Step through the bytes of a word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= 1'b0;
        end else if (issue) begin
            r_byte <= !last;
        end
    end

    // Update mask, page and RAM-select registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask    <= bmm_pkg::MASK_RESET;
            r_page0   <= 6'd0;
            r_page1   <= 6'd1 & bmm_pkg::MASK_RESET;
            r_page2   <= 6'd2 & bmm_pkg::MASK_RESET;
            r_ram_sel <= 8'h00;
        end else if (i_cfg_valid) begin
            r_mask  <= i_cfg_data;
            r_page0 <= 6'd0;
            r_page1 <= 6'd1 & i_cfg_data;
            r_page2 <= 6'd2 & i_cfg_data;
        end else if (is_write) begin
            if (cur_addr == bmm_pkg::ADDR_RAM_SEL) begin
                r_ram_sel <= cur_wbyte;
            end
            if (cur_addr == bmm_pkg::ADDR_PAGE0) begin
                r_page0 <= cur_wbyte[5:0] & r_mask;
            end
            if (cur_addr == bmm_pkg::ADDR_PAGE1) begin
                r_page1 <= cur_wbyte[5:0] & r_mask;
            end
            if (cur_addr == bmm_pkg::ADDR_PAGE2) begin
                r_page2 <= cur_wbyte[5:0] & r_mask;
            end
        end
    end

    // Tag each issued byte for the response stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_v <= 1'b0;
        end else begin
            r_tag_v <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_tag_last <= last;
            r_tag_word <= i_cmd.word;
            r_tag_src  <= (i_cmd.kind == bmm_pkg::KIND_READ) ? src : bmm_pkg::SRC_ZERO;
        end
    end

    // Select the returned byte
    always_comb begin
        case (r_tag_src)
            bmm_pkg::SRC_ROM:  rsp_byte = r_rom_q;
            bmm_pkg::SRC_CART: rsp_byte = r_cart_q;
            bmm_pkg::SRC_SYS:  rsp_byte = r_sys_q;
            default:           rsp_byte = 8'h00;
        endcase
    end

    // Collect the low byte, then load the result register
    always_ff @(posedge i_clk) begin
        if (r_tag_v && !r_tag_last) begin
            r_lo <= rsp_byte;
        end
        if (r_tag_v && r_tag_last) begin
            r_out_data <= r_tag_word ? {rsp_byte, r_lo} : {8'h00, rsp_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_tag_v && r_tag_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;

    // A finishing byte never lands on an unread result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tag_v && r_tag_last) |-> !r_out_valid)
        else $error("result register overwritten");

    // Nothing is issued while the RAMs are being cleared
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !issue)
        else $error("command issued during clearing pass");

    // The queue head stays a word command between its two bytes
    a_word_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte |-> (i_valid && i_cmd.word))
        else $error("word command lost between its bytes");

endmodule

### hdl/banked_memory_mapper_core.sv
// Top level of the banked memory mapper: front end, command queue and back end.
`timescale 1ns / 1ps

// Banked memory mapper for an 8-bit CPU bus with 16 KB ROM paging.
// Input channel (i_in_valid / o_in_ready) carries one access word: byte or
// word read, byte or word write, or a ROM image byte load. Every input word
// returns exactly one result word on the output channel (o_out_valid /
// i_out_ready); read_data is zero for writes, loads and unused codes.
// The configuration channel (i_cfg_valid / o_cfg_ready) writes the ROM bank
// mask and resets the three page registers; write it only while idle.
// An accepted word passes through the front register, the queue, the back
// end's memory and tag registers and the result register. The single-port
// memories in the back end take one byte each cycle outside the clearing pass,
// and a command's last byte waits for room in the one-deep result register.
// Reset: after i_rst_n the back end sweeps system and cartridge RAM to zero,
// one entry a cycle; inputs queue up meanwhile (up to three words),
// configuration writes are taken at once.
// A stalled receiver holds the result register; the queue and the front
// register keep accepting until both are full, then o_in_ready drops.
module banked_memory_mapper_core #(
    parameter int ROM_BANKS = bmm_pkg::ROM_BANKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_operation,
    input  logic [15:0] i_address,
    input  logic [15:0] i_write_data,
    input  logic [18:0] i_rom_offset,
    input  logic [7:0]  i_rom_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_read_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [5:0]  i_cfg_data
);

    logic          front_valid;
    logic          front_ready;
    bmm_pkg::t_cmd front_cmd;
    logic          queue_valid;
    logic          queue_ready;
    bmm_pkg::t_cmd queue_cmd;

    assign o_cfg_ready = 1'b1;

    // Classify and register incoming words
    bmm_front #(
        .ROM_BANKS (ROM_BANKS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_operation  (i_operation),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .i_rom_offset (i_rom_offset),
        .i_rom_byte   (i_rom_byte),
        .o_valid      (front_valid),
        .o_cmd        (front_cmd),
        .i_ready      (front_ready)
    );

    // Decouple front and back
    bmm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_cmd   (front_cmd),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd),
        .i_ready (queue_ready)
    );

    // Carry out accesses
    bmm_back #(
        .ROM_BANKS (ROM_BANKS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (queue_valid),
        .o_ready     (queue_ready),
        .i_cmd       (queue_cmd),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_read_data (o_read_data)
    );

endmodule

### verif/tb_banked_memory_mapper_core.sv
// Self-checking testbench for the banked memory mapper core.
`timescale 1ns / 1ps

module tb_banked_memory_mapper_core;

    // Spare operation codes, which must read back as zero and change nothing
    localparam logic [2:0] OP_SPARE5 = 3'd5;
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    localparam int ROM_SIZE    = bmm_pkg::ROM_BANKS_DEF * bmm_pkg::BANK_BYTES;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 330;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 8;
    // Slowest run: the RAM sweep plus about 2000 words with both sides
    // stalling, plus the long hold, with ample margin.
    localparam int CYCLE_LIMIT = 600000;

    localparam logic [13:0] HOT_OFFSETS [10] = '{
        14'h0000, 14'h0001, 14'h03fe, 14'h03ff, 14'h0400,
        14'h1fff, 14'h2000, 14'h2abc, 14'h3ffe, 14'h3fff
    };

    localparam logic [5:0] MASK_PLAN [PHASES] = '{
        6'd63, 6'd0, 6'd7, 6'd31, 6'd63, 6'd1
    };

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] addr;
        logic [15:0] wdata;
        logic [18:0] roff;
        logic [7:0]  rbyte;
    } t_access;

    typedef struct packed {
        t_access     acc;
        logic        known;
        logic [15:0] want;
    } t_stim_row;

    // Directed rows; run under the reset bank mask of 31
    localparam int STIM_N = 25;
    localparam t_stim_row STIM_ROWS [STIM_N] = '{
        // ROM bytes at both ends of the store and around the fixed 1 KB area
        '{'{bmm_pkg::OP_LOAD_ROM,   16'h0000, 16'h0000, 19'h00000, 8'ha5}, 1'b1, 16'h0000},
        '{'{bmm_pkg::OP_LOAD_ROM,   16'h0000, 16'h0000, 19'h7ffff, 8'h5a}, 1'b1, 16'h0000},
        '{'{bmm_pkg::OP_LOAD_ROM,   16'h0000, 16'h0000, 19'h003ff, 8'h3c}, 1'b1, 16'h0000},
        '{'{bmm_pkg::OP_LOAD_ROM,   16'h0000, 16'h0000, 19'h7c400, 8'hc3}, 1'b1, 16'h0000},
        '{'{bmm_pkg::OP_READ_BYTE,  16'h0000, 16'h0000, 19'h00000, 8'h00}, 1'b1, 16'h00a5},
        '{'{bmm_pkg::OP_READ_BYTE,  16'h03ff, 16'h0000, 19'h00000, 8'h00}, 1'b1, 16'h003c},
        // page 0 write is masked, system RAM keeps the full byte
        '{'{bmm_pkg::OP_WRITE_BYTE, 16'hfffd, 16'hffff, 19'h00000, 8'h00}, 1'b1, 16'h0000},
        '{'{bmm_pkg::OP_READ_BYTE,  16'h0400, 16'h0000, 19'h00000, 8'h00}, 1'b1, 16'h00c3},
        '{'{bmm_pkg::OP_READ_BYTE,  16'hdffd, 16'h0000, 19'h00000, 8'h00}, 1'b1, 16'h00ff},
        '{'{bmm_pkg::OP_WRITE_BYTE, 16'hffff, 16'h001f, 19'h00000, 8'h00}, 1'b1, 16'h0000},
        // word read wrapping from FFFF to 0000
        '{'{bmm_pkg::OP_READ_WORD,  16'hffff, 16'h0000, 19'h00000, 8'h00}, 1'b0, 16'h0000},
        '{'{bmm_pkg::OP_READ_BYTE,  16'hbfff, 16'h0000, 19'h00000, 8'h00}, 1'b1, 16'h005a},
        // map cartridge RAM, low half, then high half
        '{'{bmm_pkg::OP_WRITE_BYTE, 16'hfffc, 16'h0008, 19'h00000, 8'h00}, 1'b1, 16'h0000},
        '{'{bmm_pkg::OP_WRITE_WORD, 16'h8000, 16'hbeef, 19'h00000, 8'h00}, 1'b1, 16'h0000},
        '{'{bmm_pkg::OP_READ_WORD,  16'h8000, 16'h0000, 19'h00000, 8'h00}, 1'b1, 16'hbeef},
        '{'{bmm_pkg::OP_WRITE_BYTE, 16'hfffc, 16'h000c, 19'h00000, 8'h00}, 1'b1, 16'h0000},
        '{'{bmm_pkg::OP_READ_WORD,  16'h8000, 16'h0000, 19'h00000, 8'h00}, 1'b1, 16'h0000},
        // word straddling cartridge RAM and system RAM
        '{'{bmm_pkg::OP_WRITE_WORD, 16'hbfff, 16'h1234, 19'h00000, 8'h00}, 1'b1, 16'h0000},
        '{'{bmm_pkg::OP_READ_WORD,  16'hbfff, 16'h0000, 19'h00000, 8'h00}, 1'b0, 16'h0000},
        // word write hitting two control registers, unmaps cartridge RAM
        '{'{bmm_pkg::OP_WRITE_WORD, 16'hfffc, 16'h0000, 19'h00000, 8'h00}, 1'b1, 16'h0000},
        '{'{bmm_pkg::OP_WRITE_BYTE, 16'h8000, 16'h0077, 19'h00000, 8'h00}, 1'b1, 16'h0000},
        '{'{bmm_pkg::OP_WRITE_BYTE, 16'hfffc, 16'h0008, 19'h00000, 8'h00}, 1'b1, 16'h0000},
        '{'{bmm_pkg::OP_READ_BYTE,  16'h8000, 16'h0000, 19'h00000, 8'h00}, 1'b1, 16'h00ef},
        '{'{OP_SPARE7,              16'hffff, 16'hffff, 19'h7ffff, 8'hff}, 1'b1, 16'h0000},
        '{'{OP_SPARE5,              16'hc000, 16'h5555, 19'h00000, 8'h00}, 1'b1, 16'h0000}
    };

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_operation  = '0;
    logic [15:0] i_address    = '0;
    logic [15:0] i_write_data = '0;
    logic [18:0] i_rom_offset = '0;
    logic [7:0]  i_rom_byte   = '0;
    logic        o_out_valid;
    logic        i_out_ready  = 1'b0;
    logic [15:0] o_read_data;
    logic        i_cfg_valid  = 1'b0;
    logic        o_cfg_ready;
    logic [5:0]  i_cfg_data   = '0;

    // Mirror of the mapper state
    logic [7:0]                 sys_mem   [bmm_pkg::SYS_RAM_BYTES];
    logic [7:0]                 cart_mem  [bmm_pkg::CART_BYTES];
    logic [7:0]                 rom_mem   [ROM_SIZE];
    bit                         rom_valid [ROM_SIZE];
    logic [bmm_pkg::PAGE_W-1:0] page_reg  [3];
    logic [7:0]                 ram_sel;
    logic [5:0]                 bank_mask;

    logic [15:0] expected_read_data [$];

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int hold_asks      = 0;
    int hold_done      = 0;
    int hold_left      = 0;
    int err_count      = 0;
    int results_seen   = 0;
    int cycle_count    = 0;
    int n_loads        = 0;
    int n_reads        = 0;
    int n_writes       = 0;
    int n_masks        = 0;

    banked_memory_mapper_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_address   (i_address),
        .i_write_data(i_write_data),
        .i_rom_offset(i_rom_offset),
        .i_rom_byte  (i_rom_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_read_data (o_read_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Load the bank mask and fold it into the three page registers
    function automatic void set_mask(logic [5:0] m);
        bank_mask = m;
        for (int i = 0; i < 3; i++) begin
            page_reg[i] = 6'(i) & m;
        end
    endfunction

    // ROM index that a bus read of this address touches, -1 for RAM or past the store
    function automatic int rom_slot_index(logic [15:0] a);
        int bank;
        case (a[15:14])
            bmm_pkg::SLOT0: begin
                bank = (a[13:0] < bmm_pkg::FIXED_LIMIT) ? 0 : int'(page_reg[0]);
            end
            bmm_pkg::SLOT1: bank = int'(page_reg[1]);
            bmm_pkg::SLOT2: begin
                if (ram_sel[3]) return -1;
                bank = int'(page_reg[2]);
            end
            default: return -1;
        endcase
        if (bank * bmm_pkg::BANK_BYTES + int'(a[13:0]) >= ROM_SIZE) return -1;
        return bank * bmm_pkg::BANK_BYTES + int'(a[13:0]);
    endfunction

    function automatic logic [7:0] bus_peek(logic [15:0] a);
        int idx;
        if (a[15:14] == bmm_pkg::SLOT2 && ram_sel[3]) return cart_mem[{ram_sel[2], a[13:0]}];
        if (a[15:14] == bmm_pkg::SLOT3) return sys_mem[a[12:0]];
        idx = rom_slot_index(a);
        return (idx < 0) ? 8'h00 : rom_mem[idx];
    endfunction

    function automatic void bus_poke(logic [15:0] a, logic [7:0] v);
        case (a)
            bmm_pkg::ADDR_RAM_SEL: ram_sel = v;
            bmm_pkg::ADDR_PAGE0:   page_reg[0] = v[5:0] & bank_mask;
            bmm_pkg::ADDR_PAGE1:   page_reg[1] = v[5:0] & bank_mask;
            bmm_pkg::ADDR_PAGE2:   page_reg[2] = v[5:0] & bank_mask;
            default: ;
        endcase
        if (a[15:14] == bmm_pkg::SLOT3) begin
            sys_mem[a[12:0]] = v;
        end else if (a[15:14] == bmm_pkg::SLOT2 && ram_sel[3]) begin
            cart_mem[{ram_sel[2], a[13:0]}] = v;
        end
    endfunction

    // Advance the mirror by one access and return its read data
    function automatic logic [15:0] apply_access(t_access acc);
        logic [15:0] rd;
        rd = 16'h0000;
        case (acc.op)
            bmm_pkg::OP_READ_BYTE:  rd = {8'h00, bus_peek(acc.addr)};
            bmm_pkg::OP_WRITE_BYTE: bus_poke(acc.addr, acc.wdata[7:0]);
            bmm_pkg::OP_READ_WORD:  rd = {bus_peek(acc.addr + 16'd1), bus_peek(acc.addr)};
            bmm_pkg::OP_WRITE_WORD: begin
                bus_poke(acc.addr, acc.wdata[7:0]);
                bus_poke(acc.addr + 16'd1, acc.wdata[15:8]);
            end
            bmm_pkg::OP_LOAD_ROM: begin
                if (int'(acc.roff) < ROM_SIZE) begin
                    rom_mem[acc.roff]   = acc.rbyte;
                    rom_valid[acc.roff] = 1'b1;
                end
            end
            default: ;
        endcase
        return rd;
    endfunction

    function automatic logic [13:0] hot_offset();
        return HOT_OFFSETS[$urandom_range(0, 9)];
    endfunction

    task automatic note_mismatch(string what, logic [15:0] got, logic [15:0] want);
        err_count++;
        $display("MISMATCH %s at result %0d: got %h, want %h", what, results_seen, got,
                 want);
    endtask

    // Build one random access; reads that would hit unloaded ROM become loads of that byte
    task automatic make_access(output t_access acc);
        int roll;
        int idx0;
        int idx1;
        acc.addr  = 16'($urandom);
        acc.wdata = 16'($urandom);
        acc.roff  = 19'($urandom);
        acc.rbyte = 8'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 14) begin
            acc.op = bmm_pkg::OP_LOAD_ROM;
            if ($urandom_range(0, 1) == 1) begin
                acc.roff = {5'($urandom_range(0, bmm_pkg::ROM_BANKS_DEF - 1)), hot_offset()};
            end
        end else if (roll < 58) begin
            acc.op = (roll < 42) ? bmm_pkg::OP_READ_BYTE : bmm_pkg::OP_READ_WORD;
            if ($urandom_range(0, 99) < 60) acc.addr[13:0] = hot_offset();
            idx0 = rom_slot_index(acc.addr);
            idx1 = (acc.op == bmm_pkg::OP_READ_WORD) ? rom_slot_index(acc.addr + 16'd1) : -1;
            if (idx0 >= 0 && !rom_valid[idx0]) begin
                acc.op   = bmm_pkg::OP_LOAD_ROM;
                acc.roff = 19'(idx0);
            end else if (idx1 >= 0 && !rom_valid[idx1]) begin
                acc.op   = bmm_pkg::OP_LOAD_ROM;
                acc.roff = 19'(idx1);
            end
        end else if (roll < 92) begin
            acc.op = (roll < 80) ? bmm_pkg::OP_WRITE_BYTE : bmm_pkg::OP_WRITE_WORD;
            case ($urandom_range(0, 3))
                0: acc.addr = 16'hfffb + 16'($urandom_range(0, 4));
                1: acc.addr[15:14] = bmm_pkg::SLOT2;
                2: acc.addr[15:14] = bmm_pkg::SLOT3;
                default: ;
            endcase
        end else begin
            case ($urandom_range(0, 2))
                0: acc.op = OP_SPARE5;
                1: acc.op = OP_SPARE6;
                default: acc.op = OP_SPARE7;
            endcase
        end
    endtask

    // Offer one word after an optional gap, hold it until taken, then predict
    task automatic offer(t_access acc, logic known, logic [15:0] want);
        logic [15:0] rd;
        if ($urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_gap_pct);
        end
        i_in_valid   <= 1'b1;
        i_operation  <= acc.op;
        i_address    <= acc.addr;
        i_write_data <= acc.wdata;
        i_rom_offset <= acc.roff;
        i_rom_byte   <= acc.rbyte;
        do @(posedge i_clk); while (!o_in_ready);
        rd = apply_access(acc);
        expected_read_data.push_back(known ? want : rd);
        case (acc.op) inside
            bmm_pkg::OP_LOAD_ROM:                           n_loads++;
            bmm_pkg::OP_READ_BYTE, bmm_pkg::OP_READ_WORD:   n_reads++;
            bmm_pkg::OP_WRITE_BYTE, bmm_pkg::OP_WRITE_WORD: n_writes++;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (expected_read_data.size() != 0);
    endtask

    task automatic write_mask(logic [5:0] m);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        set_mask(m);
        n_masks++;
    endtask

    // Receiver: random stalls, plus one long hold on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_asks != hold_done) begin
            hold_done = hold_done + 1;
            hold_left = LONG_HOLD;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Check each delivered word against the oldest prediction
    always @(posedge i_clk) begin : check_results
        logic [15:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_read_data.size() == 0) begin
                note_mismatch("unexpected word", o_read_data, 16'h0000);
            end else begin
                want = expected_read_data.pop_front();
                if (o_read_data !== want) note_mismatch("read_data", o_read_data, want);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                     expected_read_data.size());
            $display("tb_banked_memory_mapper_core: errors");
            $finish;
        end
    end

    initial begin
        t_access acc;
        foreach (sys_mem[i]) sys_mem[i] = 8'h00;
        foreach (cart_mem[i]) cart_mem[i] = 8'h00;
        ram_sel = 8'h00;
        set_mask(bmm_pkg::MASK_RESET);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows under light sender gaps, heavy receiver stalls
        send_gap_pct   = 11;
        recv_stall_pct = 55;
        for (int r = 0; r < STIM_N; r++) begin
            offer(STIM_ROWS[r].acc, STIM_ROWS[r].known, STIM_ROWS[r].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            // Drain before touching the mask
            i_in_valid <= 1'b0;
            wait_drained();
            repeat (SETTLE) @(posedge i_clk);
            write_mask((p == 3) ? 6'($urandom_range(1, 62)) : MASK_PLAN[p]);

            case (p / 2)
                0: begin
                    send_gap_pct   = 11;
                    recv_stall_pct = 55;
                end
                1: begin
                    send_gap_pct   = 55;
                    recv_stall_pct = 11;
                end
                default: begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
            endcase

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Back up the block with a long receiver hold
                if (p == 0 && n == PHASE_ITEMS / 3) hold_asks++;
                // Let every outstanding word come home mid-phase
                if (p == 1 && n == PHASE_ITEMS / 2) begin
                    i_in_valid <= 1'b0;
                    wait_drained();
                end
                make_access(acc);
                offer(acc, 1'b0, 16'h0000);
            end
        end

        i_in_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);

        $display("covered %0d words: %0d ROM loads, %0d reads, %0d writes", results_seen,
                 n_loads, n_reads, n_writes);
        $display("across %0d bank mask settings including 0 and 63, %0d mismatches", n_masks,
                 err_count);
        if (err_count == 0) begin
            $display("tb_banked_memory_mapper_core: clean");
        end else begin
            $display("tb_banked_memory_mapper_core: errors");
        end
        $finish;
    end

endmodule
